// ===== rtl/sam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants, types and arithmetic helpers of the two-channel allpass
// section with dry/wet mix.
// ----------------------------------------------------------------------------
package sam_pkg;

  // Sizing
  localparam int MAX_DELAY    = 2048;
  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W        = $clog2(MAX_DELAY);
  localparam int LEN_W        = $clog2(MAX_DELAY + 1);
  localparam int ADDR_W       = $clog2(NUM_CHANNELS * MAX_DELAY);
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_AW      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  // Field widths
  localparam int SMP_W  = 16;
  localparam int GAIN_W = 15;
  localparam int DLY_W  = 12;
  localparam int MIX_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 3;

  // Fixed point
  localparam int Q_SHIFT  = 15;
  localparam int MIX_FULL = 32768;
  localparam int ACC_W    = 35;
  localparam int PROD1_W  = 33;
  localparam int PROD2_W  = 34;
  localparam int DIFF_W   = SMP_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_CH0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_CH1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX   = 3'd4;

  // Reset values
  localparam logic [GAIN_W-1:0] RST_GAIN_CH0  = 15'd22938;
  localparam logic [DLY_W-1:0]  RST_DELAY_CH0 = 12'd1207;
  localparam logic [GAIN_W-1:0] RST_GAIN_CH1  = 15'd14746;
  localparam logic [DLY_W-1:0]  RST_DELAY_CH1 = 12'd902;
  localparam logic [MIX_W-1:0]  RST_WET_MIX   = 16'd16384;

  // One classified sample waiting for the back end
  typedef struct packed {
    logic signed [SMP_W-1:0] x;
    logic                    blk_end;
    logic [ADDR_W-1:0]       addr;
    logic                    unwritten;  // history entry never stored: reads as zero
    logic [GAIN_W-1:0]       gain;
    logic [MIX_W-1:0]        mix;        // already clamped to full wet
  } sam_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sam_fifo_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GAIN,
    ST_STORE,
    ST_MIX
  } sam_state_t;

  // Divide by 2^15 rounding half up, then clip to the 16-bit sample range.
  function automatic logic signed [SMP_W-1:0] sat_round(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    t  = v + ACC_W'(signed'(1 <<< (Q_SHIFT - 1)));
    s  = t >>> Q_SHIFT;
    hi = ACC_W'(signed'((1 <<< (SMP_W - 1)) - 1));
    lo = -ACC_W'(signed'(1 <<< (SMP_W - 1)));
    if (s > hi) begin
      sat_round = hi[SMP_W-1:0];
    end else if (s < lo) begin
      sat_round = lo[SMP_W-1:0];
    end else begin
      sat_round = s[SMP_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/sam_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sam_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_fifo
// Short queue of classified samples between the front and back ends.
// ----------------------------------------------------------------------------
module sam_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  sam_pkg::sam_item_t      push_item,
  input  logic                    pop,
  output sam_pkg::sam_item_t      head,
  output sam_pkg::sam_fifo_stat_t stat
);

  sam_pkg::sam_item_t                store_r [sam_pkg::FIFO_DEPTH];
  logic [sam_pkg::FIFO_AW-1:0]       wptr_r, wptr_nxt;
  logic [sam_pkg::FIFO_AW-1:0]       rptr_r, rptr_nxt;
  logic [sam_pkg::FIFO_CW-1:0]       count_r, count_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == sam_pkg::FIFO_CW'(sam_pkg::FIFO_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = store_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == sam_pkg::FIFO_AW'(sam_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == sam_pkg::FIFO_AW'(sam_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/sam_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_front
// Configuration registers and sample intake: picks the channel's section,
// steps its line position and tracks how far each history has been filled.
// ----------------------------------------------------------------------------
module sam_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sam_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sam_pkg::SMP_W-1:0]   in_sample_in,
  input  logic                               in_channel,
  input  logic                               in_block_end,
  input  sam_pkg::sam_fifo_stat_t            q_stat,
  output logic                               q_push,
  output sam_pkg::sam_item_t                 q_item
);

  logic [sam_pkg::GAIN_W-1:0] gain0_r, gain1_r;
  logic [sam_pkg::DLY_W-1:0]  delay0_r, delay1_r;
  logic [sam_pkg::MIX_W-1:0]  mix_r;

  logic [sam_pkg::POS_W-1:0]  pos_r  [sam_pkg::NUM_CHANNELS];
  logic [sam_pkg::LEN_W-1:0]  fill_r [sam_pkg::NUM_CHANNELS];

  logic [sam_pkg::CH_W-1:0]   ch;
  logic [sam_pkg::DLY_W-1:0]  dly_sel;
  logic [sam_pkg::LEN_W-1:0]  len;
  logic [sam_pkg::POS_W-1:0]  pos;
  logic [sam_pkg::LEN_W-1:0]  fill;
  logic [sam_pkg::LEN_W-1:0]  pos_inc;
  logic [sam_pkg::POS_W-1:0]  pos_nxt;
  logic [sam_pkg::LEN_W-1:0]  fill_nxt;
  logic                       accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Fold out-of-range channel numbers onto the last channel
  always_comb begin
    if (32'(in_channel) >= sam_pkg::NUM_CHANNELS) begin
      ch = sam_pkg::CH_W'(sam_pkg::NUM_CHANNELS - 1);
    end else begin
      ch = sam_pkg::CH_W'(in_channel);
    end
  end

  always_comb begin
    dly_sel = (ch == '0) ? delay0_r : delay1_r;
    if (dly_sel == '0) begin
      len = sam_pkg::LEN_W'(1);
    end else if (32'(dly_sel) > sam_pkg::MAX_DELAY) begin
      len = sam_pkg::LEN_W'(sam_pkg::MAX_DELAY);
    end else begin
      len = sam_pkg::LEN_W'(dly_sel);
    end
  end

  assign pos      = pos_r[ch];
  assign fill     = fill_r[ch];
  assign pos_inc  = sam_pkg::LEN_W'(pos) + 1'b1;
  // Wrap at the delay length, also when the length was cut below the position
  assign pos_nxt  = (pos_inc >= len) ? '0 : pos_inc[sam_pkg::POS_W-1:0];
  // Positions advance one at a time from zero, so the written entries form a prefix
  assign fill_nxt = (sam_pkg::LEN_W'(pos) == fill) ? fill + 1'b1 : fill;

  always_comb begin
    q_item.x         = in_sample_in;
    q_item.blk_end   = in_block_end;
    q_item.addr      = sam_pkg::ADDR_W'(ch) * sam_pkg::ADDR_W'(sam_pkg::MAX_DELAY)
                       + sam_pkg::ADDR_W'(pos);
    q_item.unwritten = (sam_pkg::LEN_W'(pos) >= fill);
    q_item.gain      = (ch == '0) ? gain0_r : gain1_r;
    q_item.mix       = (32'(mix_r) > sam_pkg::MIX_FULL) ?
                       sam_pkg::MIX_W'(sam_pkg::MIX_FULL) : mix_r;
  end

  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain0_r  <= sam_pkg::RST_GAIN_CH0;
      delay0_r <= sam_pkg::RST_DELAY_CH0;
      gain1_r  <= sam_pkg::RST_GAIN_CH1;
      delay1_r <= sam_pkg::RST_DELAY_CH1;
      mix_r    <= sam_pkg::RST_WET_MIX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sam_pkg::REG_GAIN_CH0:  gain0_r  <= cfg_data[sam_pkg::GAIN_W-1:0];
        sam_pkg::REG_DELAY_CH0: delay0_r <= cfg_data[sam_pkg::DLY_W-1:0];
        sam_pkg::REG_GAIN_CH1:  gain1_r  <= cfg_data[sam_pkg::GAIN_W-1:0];
        sam_pkg::REG_DELAY_CH1: delay1_r <= cfg_data[sam_pkg::DLY_W-1:0];
        sam_pkg::REG_WET_MIX:   mix_r    <= cfg_data[sam_pkg::MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sam_pkg::NUM_CHANNELS; i++) begin
        pos_r[i]  <= '0;
        fill_r[i] <= '0;
      end
    end else if (accept) begin
      pos_r[ch]  <= pos_nxt;
      fill_r[ch] <= fill_nxt;
    end
  end

endmodule

// ===== rtl/sam_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_back
// Allpass and mix datapath: reads the delayed x and y, computes the new y,
// stores x and y back and forms the dry/wet output.
// ----------------------------------------------------------------------------
module sam_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sam_pkg::sam_fifo_stat_t              q_stat,
  input  sam_pkg::sam_item_t                   q_head,
  output logic                                 q_pop,
  output logic                                 ram_re,
  output logic [sam_pkg::ADDR_W-1:0]           ram_raddr,
  input  logic [2*sam_pkg::SMP_W-1:0]          ram_rdata,
  output logic                                 ram_we,
  output logic [sam_pkg::ADDR_W-1:0]           ram_waddr,
  output logic [2*sam_pkg::SMP_W-1:0]          ram_wdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sam_pkg::SMP_W-1:0]     out_sample_out,
  output logic                                 out_block_end_out
);

  sam_pkg::sam_state_t state_r, state_nxt;

  sam_pkg::sam_item_t                       cur_r;
  logic signed [sam_pkg::SMP_W-1:0]         xd_r;
  logic signed [sam_pkg::PROD1_W-1:0]       prod1_r;
  logic signed [sam_pkg::SMP_W-1:0]         y_r;
  logic signed [sam_pkg::PROD2_W-1:0]       prod2_r;
  logic signed [sam_pkg::SMP_W-1:0]         out_sample_r;
  logic                                     out_blk_r;
  logic                                     out_valid_r, out_valid_nxt;

  logic signed [sam_pkg::SMP_W-1:0]         xd;
  logic signed [sam_pkg::SMP_W-1:0]         yd;
  logic signed [sam_pkg::DIFF_W-1:0]        diff1;
  logic signed [sam_pkg::DIFF_W-1:0]        diff2;
  logic signed [sam_pkg::PROD1_W-1:0]       prod1;
  logic signed [sam_pkg::PROD2_W-1:0]       prod2;
  logic signed [sam_pkg::ACC_W-1:0]         acc_y;
  logic signed [sam_pkg::ACC_W-1:0]         acc_o;
  logic                                     out_free;
  logic                                     load_out;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sam_pkg::ST_IDLE:  if (!q_stat.empty) state_nxt = sam_pkg::ST_READ;
      sam_pkg::ST_READ:  state_nxt = sam_pkg::ST_GAIN;
      sam_pkg::ST_GAIN:  state_nxt = sam_pkg::ST_STORE;
      sam_pkg::ST_STORE: state_nxt = sam_pkg::ST_MIX;
      sam_pkg::ST_MIX:   if (out_free) state_nxt = sam_pkg::ST_IDLE;
      default:           state_nxt = sam_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop    = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      sam_pkg::ST_IDLE: begin
        q_pop  = !q_stat.empty;
        ram_re = !q_stat.empty;
      end
      sam_pkg::ST_STORE: ram_we = 1'b1;
      sam_pkg::ST_MIX:   load_out = out_free;
      default: ;
    endcase
  end

  assign ram_raddr = q_head.addr;
  assign ram_waddr = cur_r.addr;
  assign ram_wdata = {cur_r.x, y_r};

  // Never-written history entries read as zero
  assign xd = cur_r.unwritten ? '0 : ram_rdata[2*sam_pkg::SMP_W-1:sam_pkg::SMP_W];
  assign yd = cur_r.unwritten ? '0 : ram_rdata[sam_pkg::SMP_W-1:0];

  assign diff1 = sam_pkg::DIFF_W'(yd) - sam_pkg::DIFF_W'(cur_r.x);
  assign prod1 = sam_pkg::PROD1_W'(signed'({1'b0, cur_r.gain})) * sam_pkg::PROD1_W'(diff1);
  assign acc_y = sam_pkg::ACC_W'(prod1_r) + (sam_pkg::ACC_W'(xd_r) <<< sam_pkg::Q_SHIFT);

  assign diff2 = sam_pkg::DIFF_W'(y_r) - sam_pkg::DIFF_W'(cur_r.x);
  assign prod2 = sam_pkg::PROD2_W'(signed'({1'b0, cur_r.mix})) * sam_pkg::PROD2_W'(diff2);
  assign acc_o = sam_pkg::ACC_W'(prod2_r) + (sam_pkg::ACC_W'(cur_r.x) <<< sam_pkg::Q_SHIFT);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sam_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (state_r == sam_pkg::ST_READ) begin
      xd_r    <= xd;
      prod1_r <= prod1;
    end
    if (state_r == sam_pkg::ST_GAIN) begin
      y_r <= sam_pkg::sat_round(acc_y);
    end
    if (state_r == sam_pkg::ST_STORE) begin
      prod2_r <= prod2;
    end
    if (load_out) begin
      out_sample_r <= sam_pkg::sat_round(acc_o);
      out_blk_r    <= cur_r.blk_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_block_end_out = out_blk_r;

endmodule

// ===== rtl/schroeder_allpass_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schroeder_allpass_mix
// Two-channel Schroeder allpass section with dry/wet output mix.
// ----------------------------------------------------------------------------
// Each input beat carries one Q15 sample and a channel number; each produces
// exactly one output beat, y = -g*x + x[n-m] + g*y[n-m] mixed as
// wet*y + (1-wet)*x and saturated to 16 bits. The front end takes a beat and
// queues it (two entries deep); the back end gives each beat one history RAM
// read, two multiply stages with rounding and a history write, and takes no
// new beat before the last has reached the output register, so throughput is
// limited by that sequence on the shared x/y history RAM. Results wait in an
// output register while intake continues. Both histories sit in one RAM of
// NUM_CHANNELS*MAX_DELAY words holding x and y side by side; a per-channel
// fill count makes never-written entries read as zero, so no clearing pass
// is needed after reset. Write configuration only while no beat is in flight.
// ----------------------------------------------------------------------------
module schroeder_allpass_mix (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sam_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sam_pkg::SMP_W-1:0]   in_sample_in,
  input  logic                               in_channel,
  input  logic                               in_block_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sam_pkg::SMP_W-1:0]   out_sample_out,
  output logic                               out_block_end_out
);

  sam_pkg::sam_fifo_stat_t              q_stat;
  sam_pkg::sam_item_t                   q_item;
  sam_pkg::sam_item_t                   q_head;
  logic                                 q_push;
  logic                                 q_pop;
  logic                                 ram_re;
  logic                                 ram_we;
  logic [sam_pkg::ADDR_W-1:0]           ram_raddr;
  logic [sam_pkg::ADDR_W-1:0]           ram_waddr;
  logic [2*sam_pkg::SMP_W-1:0]          ram_rdata;
  logic [2*sam_pkg::SMP_W-1:0]          ram_wdata;

  sam_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .in_channel   (in_channel),
    .in_block_end (in_block_end),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  sam_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  sam_ram #(
    .WIDTH (2 * sam_pkg::SMP_W),
    .DEPTH (sam_pkg::NUM_CHANNELS * sam_pkg::MAX_DELAY)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sam_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out)
  );

endmodule

// ===== sim/sam_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_checker
// Watches the register port and both channels of the allpass mixer, keeps its
// own copy of the registers, delay lines and line positions, predicts the
// mixed sample of every accepted input beat and compares each output beat
// with the oldest prediction still due.
// ----------------------------------------------------------------------------
module sam_checker
  import sam_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SMP_W-1:0]    in_sample_in,
  input  logic                       in_channel,
  input  logic                       in_block_end,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SMP_W-1:0]    out_sample_out,
  input  logic                       out_block_end_out,
  output int                         mismatch_count,
  output int                         beats_due
);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    blk_end;
  } mixed_beat_t;

  logic [GAIN_W-1:0]       gain_q [NUM_CHANNELS];
  logic [DLY_W-1:0]        delay_q [NUM_CHANNELS];
  logic [MIX_W-1:0]        wet_q;
  logic signed [SMP_W-1:0] x_hist [NUM_CHANNELS*MAX_DELAY];
  logic signed [SMP_W-1:0] y_hist [NUM_CHANNELS*MAX_DELAY];
  int unsigned             line_pos [NUM_CHANNELS];
  mixed_beat_t             mixed_due_q [$];
  mixed_beat_t             want;

  initial begin
    mismatch_count = 0;
    beats_due      = 0;
  end

  // Divide by 2^15, round half toward +inf, clip to the sample range.
  function automatic longint round_sat_q15(longint v);
    longint s;
    s = (v + 16384) >>> Q_SHIFT;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s;
  endfunction

  function automatic mixed_beat_t allpass_mix_step(logic signed [SMP_W-1:0] x, logic ch,
                                                   logic blk);
    int unsigned len;
    int unsigned mix;
    int unsigned p;
    int unsigned addr;
    longint      xd;
    longint      yd;
    longint      y;
    mixed_beat_t r;
    len = delay_q[ch];
    if (len < 1) len = 1;
    if (len > MAX_DELAY) len = MAX_DELAY;
    mix = wet_q;
    if (mix > MIX_FULL) mix = MIX_FULL;
    p = line_pos[ch];
    if (p >= MAX_DELAY) p = 0;
    addr = ch * MAX_DELAY + p;
    xd = x_hist[addr];
    yd = y_hist[addr];
    y = round_sat_q15(longint'(gain_q[ch]) * (yd - longint'(x)) + xd * MIX_FULL);
    x_hist[addr] = x;
    y_hist[addr] = SMP_W'(y);
    // a shortened line still uses the old position once, then wraps
    p++;
    if (p >= len) p = 0;
    line_pos[ch] = p;
    r.sample  = SMP_W'(round_sat_q15(longint'(mix) * y +
                                     longint'(MIX_FULL - mix) * longint'(x)));
    r.blk_end = blk;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_q[0]  = RST_GAIN_CH0;
      delay_q[0] = RST_DELAY_CH0;
      gain_q[1]  = RST_GAIN_CH1;
      delay_q[1] = RST_DELAY_CH1;
      wet_q      = RST_WET_MIX;
      for (int i = 0; i < NUM_CHANNELS * MAX_DELAY; i++) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) line_pos[c] = 0;
      mixed_due_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        mixed_due_q.push_back(allpass_mix_step(in_sample_in, in_channel, in_block_end));
      end
      if (out_valid && !out_stall) begin
        if (mixed_due_q.size() == 0) begin
          $error("output beat with nothing due: sample_out %0d", out_sample_out);
          mismatch_count++;
        end else begin
          want = mixed_due_q.pop_front();
          if (out_sample_out !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", want.sample, out_sample_out);
            mismatch_count++;
          end
          if (out_block_end_out !== want.blk_end) begin
            $error("block_end_out: expected %0d, got %0d", want.blk_end,
                   out_block_end_out);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_CH0:  gain_q[0]  = cfg_data[GAIN_W-1:0];
          REG_DELAY_CH0: delay_q[0] = cfg_data[DLY_W-1:0];
          REG_GAIN_CH1:  gain_q[1]  = cfg_data[GAIN_W-1:0];
          REG_DELAY_CH1: delay_q[1] = cfg_data[DLY_W-1:0];
          REG_WET_MIX:   wet_q      = cfg_data[MIX_W-1:0];
          default: ;
        endcase
      end
    end
    beats_due = mixed_due_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the two-channel allpass mixer: a directed part on the sample
// extremes and the delay and mix corner cases, then random phases, each with
// its own register setting and idle pattern, checked by sam_checker.
// ----------------------------------------------------------------------------
module testbench;
  import sam_pkg::*;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RAND_PHASES     = 12;
  localparam int BEATS_PER_PHASE = 154;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample_in = '0;
  logic                    in_channel = 1'b0;
  logic                    in_block_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_sample_out;
  logic                    out_block_end_out;
  int                      mismatch_count;
  int                      beats_due;

  int  cycle_count = 0;
  int  idle_rate = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  schroeder_allpass_mix DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_in      (in_sample_in),
    .in_channel        (in_channel),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out)
  );

  sam_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_in      (in_sample_in),
    .in_channel        (in_channel),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .out_block_end_out (out_block_end_out),
    .mismatch_count    (mismatch_count),
    .beats_due         (beats_due)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Receiver: random stall bursts, none once the run goes quiet.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic send_beat(logic signed [SMP_W-1:0] s, logic ch, logic blk);
    if (!quiet && idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_channel   <= ch;
    in_block_end <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold until every predicted beat has come out.
  task automatic wait_idle();
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SMP_W'(int'($urandom_range(0, 64)) - 32);
      default: return SMP_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_W'(MAX_DELAY);
      2:       return CFG_W'($urandom_range(MAX_DELAY + 1, 4095));
      3:       return CFG_W'($urandom_range(0, 4095));
      default: return CFG_W'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_mix();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_W'(MIX_FULL);
      2:       return CFG_W'($urandom_range(MIX_FULL + 1, 65535));
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting, sample extremes on both channels.
    send_beat(16'sh7FFF, 1'b0, 1'b0);
    send_beat(16'sh8000, 1'b0, 1'b0);
    send_beat(16'sh0000, 1'b1, 1'b0);
    send_beat(-16'sd1, 1'b1, 1'b1);
    send_beat(16'sd1, 1'b0, 1'b1);
    in_valid <= 1'b0;
    wait_idle();

    // Zero delay acts as one, mix above full acts as full wet, dead indexes.
    write_reg(REG_GAIN_CH0, 16'd32767);
    write_reg(REG_DELAY_CH0, '0);
    write_reg(REG_GAIN_CH1, '0);
    write_reg(REG_DELAY_CH1, 16'd1);
    write_reg(REG_WET_MIX, 16'hFFFF);
    for (int i = REG_WET_MIX + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), CFG_W'($urandom()));
    end
    cfg_we <= 1'b0;
    for (int k = 0; k < 6; k++) begin
      send_beat(k[0] ? 16'sh8000 : 16'sh7FFF, k[1], k[0]);
    end
    in_valid <= 1'b0;
    wait_idle();

    // Delay above the line length, fully dry, gain bit beyond width dropped.
    write_reg(REG_GAIN_CH0, 16'hFFFF);
    write_reg(REG_DELAY_CH0, 16'd4095);
    write_reg(REG_GAIN_CH1, 16'h8000);
    write_reg(REG_DELAY_CH1, CFG_W'(MAX_DELAY));
    write_reg(REG_WET_MIX, '0);
    cfg_we <= 1'b0;
    send_beat(16'sh7FFF, 1'b0, 1'b0);
    send_beat(16'sh8000, 1'b0, 1'b1);
    send_beat(16'sh1234, 1'b1, 1'b0);
    send_beat(-16'sd4660, 1'b1, 1'b1);
    in_valid <= 1'b0;
    wait_idle();

    // Advance channel 0 past position 3, then shorten its line below it.
    write_reg(REG_DELAY_CH0, 16'd8);
    write_reg(REG_WET_MIX, CFG_W'(MIX_FULL));
    cfg_we <= 1'b0;
    for (int k = 0; k < 5; k++) send_beat(pick_sample(), 1'b0, 1'b0);
    in_valid <= 1'b0;
    wait_idle();
    write_reg(REG_DELAY_CH0, 16'd3);
    cfg_we <= 1'b0;
    send_beat(16'sh4000, 1'b0, 1'b0);
    send_beat(16'shC000, 1'b0, 1'b1);
    in_valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        // last stretch: no idling, strongest feedback
        quiet = 1'b1;
        write_reg(REG_GAIN_CH0, 16'd32767);
        write_reg(REG_DELAY_CH0, 16'd1);
        write_reg(REG_GAIN_CH1, 16'd32767);
        write_reg(REG_DELAY_CH1, 16'd2);
        write_reg(REG_WET_MIX, CFG_W'(MIX_FULL));
      end else begin
        idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        write_reg(REG_GAIN_CH0, pick_gain());
        write_reg(REG_DELAY_CH0, pick_delay());
        write_reg(REG_GAIN_CH1, pick_gain());
        write_reg(REG_DELAY_CH1, pick_delay());
        write_reg(REG_WET_MIX, pick_mix());
        if ($urandom_range(0, 3) == 0) begin
          write_reg(CFG_IDX_W'($urandom_range(REG_WET_MIX + 1, (1 << CFG_IDX_W) - 1)),
                    CFG_W'($urandom()));
        end
      end
      cfg_we <= 1'b0;
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        send_beat(pick_sample(), 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && beats_due == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
